FILE: rtl/mm64_pkg.sv
// Shared constants and types for the MurmurHash64A engine.
package mm64_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned LEN_W  = 32;
    localparam int unsigned HALF_W = WORD_W / 2;

    localparam logic [WORD_W-1:0] HASH_SEED = 64'hdecafbaddecafbad;
    localparam logic [WORD_W-1:0] HASH_MUL  = 64'hc6a4a7935bd1e995;
    localparam int unsigned       HASH_SHR  = 47;

    localparam logic [HALF_W-1:0] MUL_LO = HASH_MUL[HALF_W-1:0];
    localparam logic [HALF_W-1:0] MUL_HI = HASH_MUL[WORD_W-1:HALF_W];

    // Request into the shared multiplier
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] opnd;
    } t_mul_req;

    // Response from the shared multiplier
    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] prod;
    } t_mul_rsp;

endpackage

FILE: rtl/mm64_in_if.sv
// Input channel: message words with first-word flag and byte length.
interface mm64_in_if import mm64_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] data_word;
    logic              first_word;
    logic [LEN_W-1:0]  msg_length;

    modport source (output valid, output data_word, output first_word,
                    output msg_length, input ready);
    modport sink   (input valid, input data_word, input first_word,
                    input msg_length, output ready);
endinterface

FILE: rtl/mm64_out_if.sv
// Output channel: finished 64-bit hash values.
interface mm64_out_if import mm64_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

FILE: rtl/murmur64a_hash_engine_top.sv
// MurmurHash64A engine, seed 0xdecafbaddecafbad: one word at a time through a shared multiplier.
// Each 64-bit multiply by the constant runs in the shared 32x32 unit: issue, 4 steps, done.
// A full middle word is one accept and then 3 multiplies; a short last word is one accept and one multiply.
// The first word adds the length multiply; the finishing multiply and the output load are added
// to the last word. Input is not ready while a word is in work.
// Reset (synchronous, active low) closes any open message and drops a pending result.
module murmur64a_hash_engine_top import mm64_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mm64_in_if.sink         i_in,
    mm64_out_if.source      o_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_K1   = 3'd2;
    localparam logic [2:0] S_K2   = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_TAIL = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]        r_state;
    logic              r_open;
    logic              r_pend;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_acc;
    logic [WORD_W-1:0] r_k;
    logic [WORD_W-1:0] r_word;
    logic [LEN_W-1:0]  r_left;
    logic [WORD_W-1:0] r_hash;

    logic              w_in_acc;
    logic              w_mul_state;
    logic [WORD_W-1:0] w_mask;
    logic [WORD_W-1:0] w_fin;
    t_mul_req          w_req;
    t_mul_rsp          w_rsp;

    mm64_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign i_in.ready       = (r_state == S_IDLE);
    assign w_in_acc         = i_in.valid && i_in.ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.hash_value = r_hash;

    // Keep only the low bytes of a short last word
    assign w_mask = ~({WORD_W{1'b1}} << {r_left[2:0], 3'b000});
    assign w_fin  = w_rsp.prod ^ (w_rsp.prod >> HASH_SHR);

    // Pick the multiplier operand for the current step
    always_comb begin
        w_mul_state = 1'b1;
        unique case (r_state)
            S_INIT:  w_req.opnd = {{(WORD_W-LEN_W){1'b0}}, r_left};
            S_K1:    w_req.opnd = r_word;
            S_K2:    w_req.opnd = r_k ^ (r_k >> HASH_SHR);
            S_ACC:   w_req.opnd = r_acc ^ r_k;
            S_TAIL:  w_req.opnd = r_acc ^ (r_word & w_mask);
            S_FIN:   w_req.opnd = r_acc ^ (r_acc >> HASH_SHR);
            default: begin
                w_req.opnd  = r_acc;
                w_mul_state = 1'b0;
            end
        endcase
        w_req.start = w_mul_state && !r_pend;
    end

    // Sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_open      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_left      <= '0;
        end else begin
            // Load a finished hash into a free slot, drop the output once taken
            if (r_state == S_OUT && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_req.start) begin
                r_pend <= 1'b1;
            end else if (w_rsp.done) begin
                r_pend <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_in.first_word) begin
                            r_left  <= i_in.msg_length;
                            r_open  <= 1'b1;
                            r_state <= S_INIT;
                        end else if (r_open) begin
                            r_state <= (r_left >= LEN_W'(8)) ? S_K1 : S_TAIL;
                        end
                    end
                end
                S_INIT: begin
                    if (w_rsp.done) begin
                        if (r_left == '0) begin
                            r_open  <= 1'b0;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= (r_left >= LEN_W'(8)) ? S_K1 : S_TAIL;
                        end
                    end
                end
                S_K1: begin
                    if (w_rsp.done) r_state <= S_K2;
                end
                S_K2: begin
                    if (w_rsp.done) r_state <= S_ACC;
                end
                S_ACC: begin
                    if (w_rsp.done) begin
                        r_left <= r_left - LEN_W'(8);
                        if (r_left == LEN_W'(8)) begin
                            r_open  <= 1'b0;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_TAIL: begin
                    if (w_rsp.done) begin
                        r_left  <= '0;
                        r_open  <= 1'b0;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_rsp.done) r_state <= S_OUT;
                end
                S_OUT: begin
                    // Hold until the output slot is free
                    if (!r_out_valid || o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_word <= i_in.data_word;
        end
        if (w_rsp.done) begin
            case (r_state) inside
                S_INIT:         r_acc <= HASH_SEED ^ w_rsp.prod;
                S_K1, S_K2:     r_k   <= w_rsp.prod;
                S_ACC, S_TAIL:  r_acc <= w_rsp.prod;
                S_FIN:          r_acc <= w_fin;
                default:        r_acc <= r_acc;
            endcase
        end
        if (r_state == S_OUT && (!r_out_valid || o_out.ready)) begin
            r_hash <= r_acc;
        end
    end

endmodule

FILE: rtl/mm64_mul.sv
// Shared 64-bit multiplier by the hash constant, low half of the product, 32x32 per step.
module mm64_mul import mm64_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_pp;
    logic [WORD_W-1:0] r_acc;
    logic [1:0]        r_step;
    logic              r_active;
    logic              r_done;

    logic [HALF_W-1:0] w_x;
    logic [HALF_W-1:0] w_y;
    logic [WORD_W-1:0] w_pp;

    // Pick the partial product for this step: lo*lo, lo*hi, hi*lo
    always_comb begin
        case (r_step)
            2'd1: begin
                w_x = r_a[HALF_W-1:0];
                w_y = MUL_HI;
            end
            2'd2: begin
                w_x = r_a[WORD_W-1:HALF_W];
                w_y = MUL_LO;
            end
            default: begin
                w_x = r_a[HALF_W-1:0];
                w_y = MUL_LO;
            end
        endcase
        w_pp = WORD_W'(w_x) * WORD_W'(w_y);
    end

    // Control: step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_step   <= 2'd0;
            r_done   <= 1'b0;
        end else begin
            r_done <= r_active && !i_req.start && (r_step == 2'd3);
            if (i_req.start) begin
                r_active <= 1'b1;
                r_step   <= 2'd0;
            end else if (r_active) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    // Datapath: register each partial product, then fold it in
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.opnd;
        end
        if (r_active) begin
            r_pp <= w_pp;
            case (r_step) inside
                2'd1: r_acc <= r_pp;
                2'd2, 2'd3: r_acc[WORD_W-1:HALF_W] <=
                    r_acc[WORD_W-1:HALF_W] + r_pp[HALF_W-1:0];
                default: r_acc <= r_acc;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule
